@@ sv/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int INDEX_W       = 4;
    localparam int COUNT_W       = 5;
    localparam int IN_DATA_W     = 32;
    localparam int IN_USER_W     = 8;
    localparam int OUT_FIELDS_W  = STATUS_W + 1 + INDEX_W + 2 * VALUE_W + COUNT_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-transfer control broadcast to every cell of the chain.
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic                      srch;
        logic                      step;
        logic signed [VALUE_W-1:0] value;
    } ctrl_t;

endpackage

`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
// Sorted priority queue of signed 32-bit values, smallest at the head.
//
// Commands arrive on the s_ channel: s_tuser carries the command (insert,
// remove smallest, search) and s_tdata the value or search key. Each
// command yields exactly one result on the m_ channel with status, found
// flag, position of the first match, head and tail values and the count.
//
// The storage is a row of DEPTH cells. All cells compare against the
// command value in parallel and shift to their neighbor in the same cycle,
// so the list is updated at the transfer edge, where the per-cell match
// flags are registered too. They are then reduced and loaded into the
// output register once it is free, and a new command is taken every
// cycle while m_tready stays high.
//
// Reset empties the queue (count zero); cell contents are left as they are
// and cells from the count up are ignored. When the receiver stalls, the result
// is held in the output register; one more command may be taken, and its
// result waits inside until the output register frees up.
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // s_tdata: value [31:0]
    input  wire  [spq_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: cmd [1:0], zero [7:2]
    input  wire  [spq_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // m_tdata: status [1:0], found [2], found_index [6:3], head_value [38:7],
    //          tail_value [70:39], count [75:71], zero [79:76]
    output logic [spq_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = spq_pkg::VALUE_W;

    spq_pkg::ctrl_t     ctrl;
    spq_pkg::cmd_t      cmd;
    spq_pkg::status_t   status_next;
    spq_pkg::status_t   status_reg;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    out_load;
    logic signed [VW-1:0]    value;

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic signed [VW-1:0]    tail_reg;
    logic signed [VW-1:0]    tail_next;
    logic                    pend_reg;
    logic                    pend_next;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [spq_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic signed [VW-1:0]    entry_w [DEPTH];
    logic [DEPTH-1:0]        le_w;
    logic [DEPTH-1:0]        eq_w;
    logic [DEPTH-1:0]        hit_w;

    logic                         found;
    logic [spq_pkg::INDEX_W-1:0]  found_index;
    logic signed [VW-1:0]         head_out;
    logic signed [VW-1:0]         tail_out;

    assign cmd      = spq_pkg::cmd_t'(s_tuser[spq_pkg::CMD_W-1:0]);
    assign value    = $signed(s_tdata[VW-1:0]);
    assign accept   = s_tvalid && s_tready;
    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign out_load = pend_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pend_reg || out_load;

    always_comb
    begin
        ctrl        = '0;
        ctrl.step   = accept;
        ctrl.value  = value;
        status_next = spq_pkg::ST_DONE;
        count_next  = count_reg;
        tail_next   = tail_reg;
        unique case (cmd)
            spq_pkg::CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.ins   = accept;
                    if (accept)
                    begin
                        count_next = count_reg + CW'(1);
                        if (empty || value >= tail_reg)
                        begin
                            tail_next = value;
                        end
                    end
                end
            end
            spq_pkg::CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.rem = accept;
                    if (accept)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            spq_pkg::CMD_SEARCH:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.srch = accept;
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_DONE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [VW-1:0] left_entry;
            logic signed [VW-1:0] right_entry;
            logic                 left_le;
            logic                 left_eq;

            if (gi == 0)
            begin : g_first
                assign left_entry = value;
                assign left_le    = 1'b1;
                assign left_eq    = 1'b0;
            end
            else
            begin : g_inner
                assign left_entry = entry_w[gi-1];
                assign left_le    = le_w[gi-1];
                assign left_eq    = eq_w[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_entry = entry_w[gi];
            end
            else
            begin : g_body
                assign right_entry = entry_w[gi+1];
            end

            spq_cell #(
                .INDEX (gi),
                .DEPTH (DEPTH)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .left_entry  (left_entry),
                .left_le     (left_le),
                .left_eq     (left_eq),
                .right_entry (right_entry),
                .entry       (entry_w[gi]),
                .le          (le_w[gi]),
                .eq          (eq_w[gi]),
                .hit         (hit_w[gi])
            );
        end
    endgenerate

    // At most one cell flags the first match, so the position is an OR.
    always_comb
    begin
        found_index = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found_index = found_index
                        | ({spq_pkg::INDEX_W{hit_w[i]}} & spq_pkg::INDEX_W'(i));
        end
    end

    assign found    = |hit_w;
    assign head_out = empty ? '0 : entry_w[0];
    assign tail_out = empty ? '0 : tail_reg;

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (out_load)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        if (accept)
        begin
            status_reg <= status_next;
        end
        if (out_load)
        begin
            m_tdata_reg <= spq_pkg::OUT_DATA_W'({
                spq_pkg::COUNT_W'(count_reg),
                tail_out,
                head_out,
                found_index,
                found,
                status_reg
            });
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ sv/spq_cell.sv @@
`default_nettype none

module spq_cell #(
    parameter int INDEX = 0,
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire                                  clk,
    input  wire  spq_pkg::ctrl_t                 ctrl,
    input  wire  [CW-1:0]                        count,
    input  wire  signed [spq_pkg::VALUE_W-1:0]   left_entry,
    input  wire                                  left_le,
    input  wire                                  left_eq,
    input  wire  signed [spq_pkg::VALUE_W-1:0]   right_entry,
    output logic signed [spq_pkg::VALUE_W-1:0]   entry,
    output logic                                 le,
    output logic                                 eq,
    output logic                                 hit
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [spq_pkg::VALUE_W-1:0] entry_reg;
    logic signed [spq_pkg::VALUE_W-1:0] entry_next;
    logic                               hit_reg;
    logic                               hit_next;
    logic                               occupied;

    assign occupied = IDX < count;
    assign le       = occupied && (entry_reg <= ctrl.value);
    assign eq       = occupied && (entry_reg == ctrl.value);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && !le)
        begin
            // The new value lands in the first cell that holds a larger one, or else in
            // the first free cell; every cell after it takes its left neighbor's value.
            entry_next = left_le ? ctrl.value : left_entry;
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    // Equal values are contiguous, so the first match is a match whose
    // left neighbor does not match.
    assign hit_next = ctrl.srch && eq && !left_eq;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.step)
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

@@ sv/spq_checker.sv @@
`default_nettype none

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [spq_pkg::OUT_DATA_W-1:0]  m_tdata
);

    logic [spq_pkg::STATUS_W-1:0] status;
    logic                         found;
    logic signed [31:0]           head_value;
    logic signed [31:0]           tail_value;
    logic [spq_pkg::COUNT_W-1:0]  count;

    assign status     = m_tdata[1:0];
    assign found      = m_tdata[2];
    assign head_value = $signed(m_tdata[38:7]);
    assign tail_value = $signed(m_tdata[70:39]);
    assign count      = m_tdata[75:71];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && count == '0 |-> head_value == 0 && tail_value == 0)
        else $error("empty queue reports nonzero head or tail");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && count != '0 |-> head_value <= tail_value)
        else $error("head value above tail value");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && found |-> status == spq_pkg::ST_DONE)
        else $error("match reported with an error status");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == spq_pkg::ST_FULL |-> count == spq_pkg::COUNT_W'(DEPTH))
        else $error("full status without a full count");

endmodule

bind sorted_priority_queue spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
